@@ sv/mi3_pkg.sv @@
// Shared constants, types and saturation helper for the 3x3 matrix inverse unit.
`default_nettype none

package mi3_pkg;

   localparam int DEF_FRAC_BITS = 16;

   localparam int EL_W      = 32;   // matrix element width
   localparam int N_EL      = 9;    // elements per matrix
   localparam int N_ROW     = 3;
   localparam int PROD_W    = 64;   // element by element product
   localparam int ADJ_W     = 65;   // signed 2x2 cofactor
   localparam int ADJ_MAG_W = 64;   // cofactor magnitude
   localparam int LO_W      = 32;   // low slice of a cofactor for the split multiply
   localparam int PART_W    = 65;   // partial product width
   localparam int DET_W     = 98;   // signed exact determinant
   localparam int MAG_W     = 96;   // determinant magnitude
   localparam int QUOT_W    = 32;   // quotient bits

   // Pipeline map: global stage numbers
   localparam int ST_COF = 0;
   localparam int N_COF  = 2;
   localparam int ST_MRG = ST_COF + N_COF;
   localparam int N_MRG  = 4;
   localparam int ST_DIV = ST_MRG + N_MRG;
   localparam int DIV_ST = QUOT_W + 1;          // range check, then one bit a stage
   localparam int ST_OUT = ST_DIV + DIV_ST;
   localparam int N_ST   = ST_OUT + 1;

   localparam logic [EL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [EL_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef logic [3:0] el_idx_type;

   // Cofactor k = a[i0]*a[i1] - a[i2]*a[i3], transposed for the adjugate
   localparam el_idx_type CF_IDX [N_EL][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   typedef struct packed {
      logic            clip;
      logic [EL_W-1:0] value;
   } sat_type;

   typedef struct packed {
      logic            zero;
      logic            clip;
      logic [EL_W-1:0] value;
   } det_info_type;

   // Signed result from magnitude and sign, clipped to 32 bits.
   // big: magnitude already known to exceed 32 bits.
   function automatic sat_type sat_mag(input logic big, input logic [EL_W-1:0] m,
                                       input logic neg);
      sat_type s;
      s.clip  = 1'b0;
      s.value = neg ? EL_W'(-m) : m;
      if (!neg && (big || m[EL_W-1])) begin
         s.clip  = 1'b1;
         s.value = SAT_POS;
      end else if (neg && (big || (m > SAT_NEG))) begin
         s.clip  = 1'b1;
         s.value = SAT_NEG;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

@@ sv/mi3_cof_lane.sv @@
// One cofactor lane: two registered products, then their registered difference.
`default_nettype none

module mi3_cof_lane
   import mi3_pkg::*;
(
   input  logic                    clock,
   input  logic [N_COF-1:0]        en,
   input  logic signed [EL_W-1:0]  x_a,
   input  logic signed [EL_W-1:0]  x_b,
   input  logic signed [EL_W-1:0]  y_a,
   input  logic signed [EL_W-1:0]  y_b,
   output logic signed [ADJ_W-1:0] adj
);

   logic signed [PROD_W-1:0] p_ff;
   logic signed [PROD_W-1:0] q_ff;
   logic signed [ADJ_W-1:0]  adj_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_ff <= x_a * x_b;
         q_ff <= y_a * y_b;
      end
      if (en[1]) begin
         adj_ff <= ADJ_W'(p_ff) - ADJ_W'(q_ff);
      end
   end

   assign adj = adj_ff;

endmodule

`default_nettype wire

@@ sv/mi3_det_merge.sv @@
// Merge stage: determinant from first-row cofactors, magnitude, divider operands.
`default_nettype none

module mi3_det_merge
   import mi3_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
   input  logic                                clock,
   input  logic [N_MRG-1:0]                    en,
   input  logic signed [ADJ_W-1:0]             adj_in [N_EL],
   input  logic signed [EL_W-1:0]              row    [N_ROW],
   output logic [ADJ_MAG_W+2*FRAC_BITS-1:0]    num    [N_EL],
   output logic                                quot_neg [N_EL],
   output logic [MAG_W-1:0]                    mag,
   output det_info_type                        det_info
);

   localparam int NUM_W = ADJ_MAG_W + 2*FRAC_BITS;
   localparam int SH    = 2*FRAC_BITS;

   logic signed [PART_W-1:0] lo_ff   [N_ROW];
   logic signed [PART_W-1:0] hi_ff   [N_ROW];
   logic signed [DET_W-1:0]  term_ff [N_ROW];
   logic signed [DET_W-1:0]  det_ff;
   logic signed [ADJ_W-1:0]  adj_a_ff [N_EL];
   logic signed [ADJ_W-1:0]  adj_b_ff [N_EL];
   logic signed [ADJ_W-1:0]  adj_c_ff [N_EL];

   logic [NUM_W-1:0]   num_ff [N_EL];
   logic               qneg_ff [N_EL];
   logic [MAG_W-1:0]   mag_ff;
   det_info_type       dinfo_ff;

   logic               dneg;
   logic [DET_W-1:0]   det_abs;
   logic               big;
   logic [EL_W-1:0]    m32;
   sat_type            dsat;
   logic [NUM_W-1:0]   num_c  [N_EL];
   logic               qneg_c [N_EL];
   logic [ADJ_W-1:0]   adj_abs;

   // first-row cofactors sit at adjugate entries 0, 3 and 6
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int j = 0; j < N_ROW; j++) begin
            lo_ff[j] <= $signed({1'b0, adj_in[3*j][LO_W-1:0]}) * row[j];
            hi_ff[j] <= $signed(adj_in[3*j][ADJ_W-1:LO_W]) * row[j];
         end
         adj_a_ff <= adj_in;
      end
      if (en[1]) begin
         for (int j = 0; j < N_ROW; j++) begin
            term_ff[j] <= $signed({hi_ff[j][PART_W-1], hi_ff[j], {LO_W{1'b0}}})
                          + DET_W'(lo_ff[j]);
         end
         adj_b_ff <= adj_a_ff;
      end
      if (en[2]) begin
         det_ff   <= term_ff[0] + term_ff[1] + term_ff[2];
         adj_c_ff <= adj_b_ff;
      end
      if (en[3]) begin
         num_ff   <= num_c;
         qneg_ff  <= qneg_c;
         mag_ff   <= det_abs[MAG_W-1:0];
         dinfo_ff <= '{zero: (det_ff == '0), clip: dsat.clip, value: dsat.value};
      end
   end

   always_comb begin
      dneg    = det_ff[DET_W-1];
      det_abs = dneg ? DET_W'(-det_ff) : DET_W'(det_ff);
      big     = |det_abs[DET_W-1:SH+EL_W];
      m32     = det_abs[SH+EL_W-1:SH];
      dsat    = sat_mag(big, m32, dneg);
      for (int i = 0; i < N_EL; i++) begin
         adj_abs   = adj_c_ff[i][ADJ_W-1] ? ADJ_W'(-adj_c_ff[i]) : ADJ_W'(adj_c_ff[i]);
         num_c[i]  = NUM_W'(adj_abs[ADJ_MAG_W-1:0]) << SH;
         qneg_c[i] = adj_c_ff[i][ADJ_W-1] ^ dneg;
      end
   end

   assign num      = num_ff;
   assign quot_neg = qneg_ff;
   assign mag      = mag_ff;
   assign det_info = dinfo_ff;

endmodule

`default_nettype wire

@@ sv/mi3_div_lane.sv @@
// Pipelined restoring divider lane: range check, then one quotient bit a stage.
`default_nettype none

module mi3_div_lane
   import mi3_pkg::*;
#(
   parameter int NUM_W = ADJ_MAG_W + 2*DEF_FRAC_BITS
)
(
   input  logic              clock,
   input  logic [DIV_ST-1:0] en,
   input  logic [NUM_W-1:0]  num,
   input  logic              neg_in,
   input  logic [MAG_W-1:0]  mag_stage [DIV_ST],
   output logic [QUOT_W-1:0] quot,
   output logic              ovf,
   output logic              neg
);

   localparam int CMP_W = MAG_W + QUOT_W + 1;

   logic [NUM_W-1:0]  r_ff   [DIV_ST];
   logic [QUOT_W-1:0] q_ff   [DIV_ST];
   logic              ovf_ff [DIV_ST];
   logic              neg_ff [DIV_ST];

   // quotient needs more than 32 bits when num >= mag * 2^32
   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0]   <= num;
         q_ff[0]   <= '0;
         ovf_ff[0] <= CMP_W'(num) >= (CMP_W'(mag_stage[0]) << QUOT_W);
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar k = 1; k < DIV_ST; k++) begin : g_step
      localparam int SH = DIV_ST - 1 - k;
      logic [CMP_W-1:0] rem_x;
      logic [CMP_W-1:0] div_x;
      logic [CMP_W-1:0] diff;
      logic             ge;

      assign rem_x = CMP_W'(r_ff[k-1]);
      assign div_x = CMP_W'(mag_stage[k]) << SH;
      assign ge    = (rem_x >= div_x);
      assign diff  = rem_x - div_x;

      always_ff @(posedge clock) begin
         if (en[k]) begin
            r_ff[k]   <= ge ? NUM_W'(diff) : r_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (ge ? (QUOT_W'(1) << SH) : '0);
            ovf_ff[k] <= ovf_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign quot = q_ff[DIV_ST-1];
   assign ovf  = ovf_ff[DIV_ST-1];
   assign neg  = neg_ff[DIV_ST-1];

endmodule

`default_nettype wire

@@ sv/matrix_inverse_3x3_unit.sv @@
// Top level of the 3x3 matrix inverse unit: handshake, lanes and output register.
`default_nettype none

// Inverts one 3x3 matrix of signed fixed-point elements (FRAC_BITS fraction
// bits, Q16.16 by default) per item as adjugate over determinant. Cofactors
// and determinant are exact; each inverse element is truncated toward zero and
// clipped to 32 bits, the determinant likewise. An exactly zero determinant
// gives singular = 1 with all values zero; any clip raises saturated. The unit
// accepts one item every cycle while the result side does not stall; behind
// the cofactor and merge stages sit the nine 33-stage divider lanes (a range
// check and one quotient bit per stage). Each stage holds its item only while
// the next one is full, so bubbles close up and new items are taken while a
// finished result waits on rsp_stall. No state survives an item.
module matrix_inverse_3x3_unit
   import mi3_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [EL_W-1:0] req_a00,
   input  logic signed [EL_W-1:0] req_a01,
   input  logic signed [EL_W-1:0] req_a02,
   input  logic signed [EL_W-1:0] req_a10,
   input  logic signed [EL_W-1:0] req_a11,
   input  logic signed [EL_W-1:0] req_a12,
   input  logic signed [EL_W-1:0] req_a20,
   input  logic signed [EL_W-1:0] req_a21,
   input  logic signed [EL_W-1:0] req_a22,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [EL_W-1:0] rsp_b00,
   output logic signed [EL_W-1:0] rsp_b01,
   output logic signed [EL_W-1:0] rsp_b02,
   output logic signed [EL_W-1:0] rsp_b10,
   output logic signed [EL_W-1:0] rsp_b11,
   output logic signed [EL_W-1:0] rsp_b12,
   output logic signed [EL_W-1:0] rsp_b20,
   output logic signed [EL_W-1:0] rsp_b21,
   output logic signed [EL_W-1:0] rsp_b22,
   output logic signed [EL_W-1:0] rsp_determinant,
   output logic                   rsp_singular,
   output logic                   rsp_saturated
);

   localparam int NUM_W = ADJ_MAG_W + 2*FRAC_BITS;

   // ---- stage occupancy and hold chain ----
   logic [N_ST-1:0] v_ff;
   logic [N_ST:0]   rdy;

   assign rdy[N_ST] = !rsp_stall;
   for (genvar k = 0; k < N_ST; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < N_ST; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = v_ff[N_ST-1];

   // ---- input matrix, row-major ----
   logic signed [EL_W-1:0] a_w [N_EL];

   assign a_w[0] = req_a00;
   assign a_w[1] = req_a01;
   assign a_w[2] = req_a02;
   assign a_w[3] = req_a10;
   assign a_w[4] = req_a11;
   assign a_w[5] = req_a12;
   assign a_w[6] = req_a20;
   assign a_w[7] = req_a21;
   assign a_w[8] = req_a22;

   // first row rides alongside the cofactor stages for the expansion
   logic signed [EL_W-1:0] row0_ff [N_ROW];
   logic signed [EL_W-1:0] row1_ff [N_ROW];

   always_ff @(posedge clock) begin
      if (rdy[ST_COF]) begin
         for (int j = 0; j < N_ROW; j++) row0_ff[j] <= a_w[j];
      end
      if (rdy[ST_COF+1]) begin
         row1_ff <= row0_ff;
      end
   end

   // ---- nine cofactor lanes ----
   logic signed [ADJ_W-1:0] adj_w [N_EL];

   for (genvar i = 0; i < N_EL; i++) begin : g_cof
      mi3_cof_lane u_cof (
         .clock (clock),
         .en    (rdy[ST_COF +: N_COF]),
         .x_a   (a_w[CF_IDX[i][0]]),
         .x_b   (a_w[CF_IDX[i][1]]),
         .y_a   (a_w[CF_IDX[i][2]]),
         .y_b   (a_w[CF_IDX[i][3]]),
         .adj   (adj_w[i])
      );
   end

   // ---- merge: determinant and divider operands ----
   logic [NUM_W-1:0] mrg_num  [N_EL];
   logic             mrg_qneg [N_EL];
   logic [MAG_W-1:0] mrg_mag;
   det_info_type     mrg_dinfo;

   mi3_det_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock    (clock),
      .en       (rdy[ST_MRG +: N_MRG]),
      .adj_in   (adj_w),
      .row      (row1_ff),
      .num      (mrg_num),
      .quot_neg (mrg_qneg),
      .mag      (mrg_mag),
      .det_info (mrg_dinfo)
   );

   // ---- divisor shared by the lanes, one copy per divider stage ----
   logic [MAG_W-1:0] mag_ff [1:DIV_ST-1];
   logic [MAG_W-1:0] mag_p  [DIV_ST];
   det_info_type     dinfo_ff [DIV_ST];

   always_ff @(posedge clock) begin
      for (int k = 1; k < DIV_ST; k++) begin
         if (rdy[ST_DIV+k-1]) mag_ff[k] <= mag_p[k-1];
      end
      if (rdy[ST_DIV]) dinfo_ff[0] <= mrg_dinfo;
      for (int k = 1; k < DIV_ST; k++) begin
         if (rdy[ST_DIV+k]) dinfo_ff[k] <= dinfo_ff[k-1];
      end
   end

   always_comb begin
      mag_p[0] = mrg_mag;
      for (int k = 1; k < DIV_ST; k++) mag_p[k] = mag_ff[k];
   end

   // ---- nine divider lanes ----
   logic [QUOT_W-1:0] q_w   [N_EL];
   logic              ovf_w [N_EL];
   logic              neg_w [N_EL];

   for (genvar i = 0; i < N_EL; i++) begin : g_div
      mi3_div_lane #(.NUM_W(NUM_W)) u_div (
         .clock     (clock),
         .en        (rdy[ST_DIV +: DIV_ST]),
         .num       (mrg_num[i]),
         .neg_in    (mrg_qneg[i]),
         .mag_stage (mag_p),
         .quot      (q_w[i]),
         .ovf       (ovf_w[i]),
         .neg       (neg_w[i])
      );
   end

   // ---- output register: sign, clip, singular override ----
   sat_type         lane_sat [N_EL];
   logic            any_clip;
   det_info_type    dfin;
   logic [EL_W-1:0] b_ff [N_EL];
   logic [EL_W-1:0] det_ff;
   logic            sing_ff;
   logic            sat_ff;

   always_comb begin
      dfin     = dinfo_ff[DIV_ST-1];
      any_clip = dfin.clip;
      for (int i = 0; i < N_EL; i++) begin
         lane_sat[i] = sat_mag(ovf_w[i], q_w[i], neg_w[i]);
         any_clip    = any_clip | lane_sat[i].clip;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_OUT]) begin
         for (int i = 0; i < N_EL; i++) begin
            b_ff[i] <= dfin.zero ? '0 : lane_sat[i].value;
         end
         det_ff  <= dfin.zero ? '0 : dfin.value;
         sing_ff <= dfin.zero;
         sat_ff  <= !dfin.zero && any_clip;
      end
   end

   assign rsp_b00         = b_ff[0];
   assign rsp_b01         = b_ff[1];
   assign rsp_b02         = b_ff[2];
   assign rsp_b10         = b_ff[3];
   assign rsp_b11         = b_ff[4];
   assign rsp_b12         = b_ff[5];
   assign rsp_b20         = b_ff[6];
   assign rsp_b21         = b_ff[7];
   assign rsp_b22         = b_ff[8];
   assign rsp_determinant = det_ff;
   assign rsp_singular    = sing_ff;
   assign rsp_saturated   = sat_ff;

   // ---- checks ----
   // singular result carries nothing but the flag
   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated && rsp_determinant == '0)
      else $error("singular item with non-zero determinant or saturated flag");

   // a full pipe with a held result must push back on the input
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && rsp_stall |-> req_stall)
      else $error("input taken while every stage is occupied and output held");

   // reset empties every stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> v_ff == '0)
      else $error("stage occupancy not cleared by reset");

endmodule

`default_nettype wire

@@ dv/matrix_inverse_3x3_unit_checker.sv @@
// Watches both channels of the matrix inverse unit, predicts each inverse and compares it.
`timescale 1ns / 100ps

module matrix_inverse_3x3_unit_checker
   import mi3_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [N_EL-1:0][EL_W-1:0]  req_a,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [N_EL-1:0][EL_W-1:0]  rsp_b,
   input  logic [EL_W-1:0]            rsp_determinant,
   input  logic                       rsp_singular,
   input  logic                       rsp_saturated,
   output int                         fail_count,
   output int                         inverses_pending
);

   typedef logic signed [129:0] wide_type;

   typedef struct {
      logic [EL_W-1:0] b [N_EL];
      logic [EL_W-1:0] det;
      logic            singular;
      logic            saturated;
   } inverse_type;

   inverse_type expected_inverses [$];

   function automatic logic [EL_W-1:0] clip32(input logic [129:0] mag, input logic neg,
                                              inout logic clip);
      if (!neg && mag > 130'h7FFF_FFFF) begin
         clip = 1'b1;
         return SAT_POS;
      end
      if (neg && mag > 130'h8000_0000) begin
         clip = 1'b1;
         return SAT_NEG;
      end
      return neg ? EL_W'(-mag) : EL_W'(mag);
   endfunction

   function automatic inverse_type invert_matrix(input logic [N_EL-1:0][EL_W-1:0] m);
      inverse_type  r;
      wide_type     e [N_EL];
      wide_type     cof [N_EL];
      wide_type     det;
      logic [129:0] dmag, amag, quo;
      logic         dneg, clip;
      for (int i = 0; i < N_EL; i++) e[i] = signed'(m[i]);
      // adjugate: transposed cofactors
      cof[0] = e[4]*e[8] - e[5]*e[7];
      cof[1] = e[2]*e[7] - e[1]*e[8];
      cof[2] = e[1]*e[5] - e[2]*e[4];
      cof[3] = e[5]*e[6] - e[3]*e[8];
      cof[4] = e[0]*e[8] - e[2]*e[6];
      cof[5] = e[2]*e[3] - e[0]*e[5];
      cof[6] = e[3]*e[7] - e[4]*e[6];
      cof[7] = e[1]*e[6] - e[0]*e[7];
      cof[8] = e[0]*e[4] - e[1]*e[3];
      det = e[0]*cof[0] + e[1]*cof[3] + e[2]*cof[6];
      clip = 1'b0;
      if (det == 0) begin
         foreach (r.b[i]) r.b[i] = '0;
         r.det = '0;
         r.singular = 1'b1;
         r.saturated = 1'b0;
         return r;
      end
      dneg = det < 0;
      dmag = dneg ? -det : det;
      r.det = clip32(dmag >> (2*FRAC_BITS), dneg, clip);
      for (int i = 0; i < N_EL; i++) begin
         amag = cof[i] < 0 ? -cof[i] : cof[i];
         quo  = (amag << (2*FRAC_BITS)) / dmag;
         r.b[i] = clip32(quo, (cof[i] < 0) != dneg, clip);
      end
      r.singular = 1'b0;
      r.saturated = clip;
      return r;
   endfunction

   const string el_name [N_EL] = '{"b00", "b01", "b02", "b10", "b11", "b12",
                                   "b20", "b21", "b22"};

   always @(posedge clock) begin
      inverse_type want;
      logic        bad;
      if (reset) begin
         fail_count       <= 0;
         inverses_pending <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_inverses.push_back(invert_matrix(req_a));
         if (rsp_valid && !rsp_stall) begin
            if (expected_inverses.size() == 0) begin
               $error("result item with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_inverses.pop_front();
               bad  = (want.det != rsp_determinant) || (want.singular != rsp_singular)
                      || (want.saturated != rsp_saturated);
               for (int i = 0; i < N_EL; i++)
                  if (want.b[i] != rsp_b[i]) bad = 1'b1;
               if (bad) begin
                  fail_count <= fail_count + 1;
                  for (int i = 0; i < N_EL; i++)
                     if (want.b[i] != rsp_b[i])
                        $error("%s expected %0d got %0d", el_name[i],
                               $signed(want.b[i]), $signed(rsp_b[i]));
                  if (want.det != rsp_determinant)
                     $error("determinant expected %0d got %0d", $signed(want.det),
                            $signed(rsp_determinant));
                  if (want.singular != rsp_singular)
                     $error("singular expected %0d got %0d", want.singular, rsp_singular);
                  if (want.saturated != rsp_saturated)
                     $error("saturated expected %0d got %0d", want.saturated,
                            rsp_saturated);
               end
            end
         end
         inverses_pending <= expected_inverses.size();
      end
   end

endmodule

@@ dv/matrix_inverse_3x3_unit_test.sv @@
// Stimulus and verdict for the 3x3 matrix inverse unit.
`timescale 1ns / 100ps

module matrix_inverse_3x3_unit_test
   import mi3_pkg::*;
();

   localparam int ONE       = 32'h0001_0000;   // 1.0 in Q16.16
   localparam int N_RANDOM  = 1130;
   localparam int DRAIN     = 80;              // comfortably past the unit's latency

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [N_EL-1:0][EL_W-1:0] req_a = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [N_EL-1:0][EL_W-1:0] rsp_b;
   logic [EL_W-1:0]           rsp_determinant;
   logic                      rsp_singular;
   logic                      rsp_saturated;
   int                        fail_count;
   int                        inverses_pending;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   matrix_inverse_3x3_unit dut (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_a00(req_a[0]), .req_a01(req_a[1]), .req_a02(req_a[2]),
      .req_a10(req_a[3]), .req_a11(req_a[4]), .req_a12(req_a[5]),
      .req_a20(req_a[6]), .req_a21(req_a[7]), .req_a22(req_a[8]),
      .rsp_valid, .rsp_stall,
      .rsp_b00(rsp_b[0]), .rsp_b01(rsp_b[1]), .rsp_b02(rsp_b[2]),
      .rsp_b10(rsp_b[3]), .rsp_b11(rsp_b[4]), .rsp_b12(rsp_b[5]),
      .rsp_b20(rsp_b[6]), .rsp_b21(rsp_b[7]), .rsp_b22(rsp_b[8]),
      .rsp_determinant, .rsp_singular, .rsp_saturated
   );

   matrix_inverse_3x3_unit_checker inverse_checker (
      .clock, .reset, .req_valid, .req_stall, .req_a,
      .rsp_valid, .rsp_stall, .rsp_b, .rsp_determinant, .rsp_singular, .rsp_saturated,
      .fail_count, .inverses_pending
   );

   // Offers one matrix and returns once it has been taken. Valid stays high on
   // return so back-to-back items need no lowering in between.
   task automatic offer_matrix(input logic [N_EL-1:0][EL_W-1:0] m);
      req_valid <= 1'b1;
      req_a     <= m;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Sender pause until every result item is back; one edge first so the
   // pending count has seen the last item taken
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (inverses_pending != 0) @(posedge clock);
   endtask

   function automatic logic [N_EL-1:0][EL_W-1:0] diag(input logic [EL_W-1:0] d);
      logic [N_EL-1:0][EL_W-1:0] m;
      m = '0;
      m[0] = d; m[4] = d; m[8] = d;
      return m;
   endfunction

   function automatic logic [EL_W-1:0] small_el(input int span);
      return EL_W'($urandom_range(0, 2*span) - span);
   endfunction

   // Mostly well-conditioned matrices of modest size, so the inverse lands in
   // range; the rest are raw 32-bit noise, singular and tiny-determinant cases.
   function automatic logic [N_EL-1:0][EL_W-1:0] random_matrix();
      logic [N_EL-1:0][EL_W-1:0] m;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < N_EL; i++) begin
         case (kind)
            0, 1:    m[i] = $urandom;
            2, 3, 4: m[i] = small_el(4*ONE);
            5, 6:    m[i] = small_el(ONE/2);
            7:       m[i] = small_el(255);
            default: m[i] = small_el(ONE);
         endcase
      end
      if (kind == 5 || kind == 6) begin
         // diagonally dominant
         m[0] = m[0] + 4*ONE; m[4] = m[4] - 4*ONE; m[8] = m[8] + 3*ONE;
      end else if (kind == 8) begin
         // repeated row gives an exactly zero determinant
         m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end else if (kind == 9 && $urandom_range(0, 1)) begin
         // column that is a multiple of another
         m[2] = m[0] <<< 1; m[5] = m[3] <<< 1; m[8] = m[6] <<< 1;
      end
      return m;
   endfunction

   // Receiver: stall mode is redrawn periodically from four patterns; twice a long hold while the
   // sender keeps going so the pipeline fills and backs up into req_stall.
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 64 == 0) mode = $urandom_range(0, 3);
         if ((cyc >= 300 && cyc < 700) || (cyc >= 1200 && cyc < 1450))
            rsp_stall <= 1'b1;
         else case (mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= $urandom_range(0, 1);
         endcase
      end
   end

   initial begin
      #2_000_000;
      $display("matrix_inverse_3x3_unit test failed");
      $finish;
   end

   initial begin
      logic [N_EL-1:0][EL_W-1:0] m;
      logic [N_EL-1:0][EL_W-1:0] directed [$];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, scaled identities, zero, extremes, tiny determinant
      directed.push_back(diag(ONE));
      directed.push_back(diag(2*ONE));
      directed.push_back(diag(-ONE/2));
      directed.push_back('0);                          // singular, all zero
      directed.push_back(diag(32'd1));                 // tiny determinant, inverse clips
      directed.push_back(diag(32'h7FFF_FFFF));
      directed.push_back(diag(32'h8000_0000));
      directed.push_back({N_EL{32'h7FFF_FFFF}});       // all equal: singular
      directed.push_back({N_EL{32'h8000_0000}});
      m = diag(32'h8000_0000); m[1] = 32'h7FFF_FFFF; m[5] = 32'hFFFF_FFFF;
      directed.push_back(m);
      m = diag(32'h7FFF_FFFF); m[2] = 32'h8000_0000; m[6] = 32'h8000_0000;
      directed.push_back(m);
      m = '0; m[2] = ONE; m[4] = ONE; m[6] = ONE;      // anti-diagonal permutation
      directed.push_back(m);
      m = diag(ONE); m[1] = 3*ONE; m[3] = -2*ONE; m[7] = ONE/4;
      directed.push_back(m);
      m = diag(32'hFFFF_FFFF);                         // -1 ulp each, tiny negative det
      directed.push_back(m);
      m = diag(ONE); m[8] = 32'd3;                     // small det, large inverse entry
      directed.push_back(m);
      m = diag(ONE); m[3] = ONE; m[4] = ONE;           // lower-triangular, determinant 1.0
      directed.push_back(m);
      foreach (directed[i]) offer_matrix(directed[i]);
      drain_results();

      for (int n = 0; n < N_RANDOM; n++) begin
         offer_matrix(random_matrix());
         if ($urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 12));
         if (n == 600) drain_results();
      end

      drain_results();
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0 && inverses_pending == 0)
         $display("matrix_inverse_3x3_unit test passed");
      else
         $display("matrix_inverse_3x3_unit test failed");
      $finish;
   end

endmodule
